// File: rtl/sou_pkg.sv
`default_nettype none

package sou_pkg;

  localparam int N_DRIVE   = 1;
  localparam int N_MEASURE = 2;
  localparam int QUEUE_DEPTH = 2;

  // input item kinds
  localparam logic [1:0] KIND_STEP = 2'd0;
  localparam logic [1:0] KIND_COEF = 2'd1;
  localparam logic [1:0] KIND_EST  = 2'd2;

  localparam logic [63:0] ROUND_BIAS = 64'h0000_0000_0080_0000;
  localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN    = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_STEP,
    OP_COEF,
    OP_EST
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  index;
    logic [31:0] value;
    logic [31:0] drive;
    logic [31:0] rate;
    logic [31:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        clip;
  } rs_t;

  // Round half up from Q24.40 to Q16.16, then clip to 32 bits.
  function automatic rs_t round_sat(input logic [63:0] acc);
    logic [63:0] s;
    logic [39:0] q;
    rs_t         r;
    s = acc + ROUND_BIAS;
    q = s[63:24];
    if (q[39:31] != {9{q[39]}}) begin
      r.clip  = 1'b1;
      r.value = q[39] ? SAT_MIN : SAT_MAX;
    end else begin
      r.clip  = 1'b0;
      r.value = q[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/state_observer_update_top.sv
// Step item: the N_STATE new estimates are computed row by row on the shared
// multiply-accumulate, each from ROW_LEN terms, and the next queued command is
// taken only once the step has committed its last row; write items wait for idle.
// A two-entry command queue lets the input side run ahead of the execution side.
// Reset (synchronous, active high) clears the estimates and all control state;
// the coefficient memory is not cleared and must be written before a step reads it.
`default_nettype none

module state_observer_update_top #(
  parameter int N_STATE = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [4:0]  element_index,
  input  wire logic [31:0] write_value,
  input  wire logic [31:0] drive_input,
  input  wire logic [31:0] measured_rate,
  input  wire logic [31:0] measured_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       estimate_index,
  output logic [31:0]      estimate_value,
  output logic             saturated,
  output logic             last
);

  logic          cmd_vld;
  logic          cmd_take;
  sou_pkg::cmd_t cmd;

  sou_front #(
    .N_STATE (N_STATE)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .element_index  (element_index),
    .write_value    (write_value),
    .drive_input    (drive_input),
    .measured_rate  (measured_rate),
    .measured_angle (measured_angle),
    .cmd_vld        (cmd_vld),
    .cmd            (cmd),
    .cmd_take       (cmd_take)
  );

  sou_back #(
    .N_STATE (N_STATE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_vld        (cmd_vld),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .estimate_index (estimate_index),
    .estimate_value (estimate_value),
    .saturated      (saturated),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: rtl/sou_front.sv
`default_nettype none

module sou_front #(
  parameter int N_STATE = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       kind,
  input  wire logic [4:0]       element_index,
  input  wire logic [31:0]      write_value,
  input  wire logic [31:0]      drive_input,
  input  wire logic [31:0]      measured_rate,
  input  wire logic [31:0]      measured_angle,
  output logic                  cmd_vld,
  output sou_pkg::cmd_t         cmd,
  input  wire logic             cmd_take
);

  localparam int ROW_LEN    = N_STATE + sou_pkg::N_DRIVE + sou_pkg::N_MEASURE;
  localparam int COEF_DEPTH = N_STATE * ROW_LEN;
  localparam int PTR_W      = $clog2(sou_pkg::QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(sou_pkg::QUEUE_DEPTH + 1);

  sou_pkg::cmd_t    queue [sou_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  sou_pkg::cmd_t in_cmd;
  logic          keep;
  logic          push;
  logic          pop;

  // classify: drop unknown kinds and out-of-range writes here
  always_comb begin
    in_cmd.index = element_index;
    in_cmd.value = write_value;
    in_cmd.drive = drive_input;
    in_cmd.rate  = measured_rate;
    in_cmd.angle = measured_angle;
    in_cmd.op    = sou_pkg::OP_STEP;
    keep         = 1'b0;
    case (kind)
      sou_pkg::KIND_STEP: begin
        in_cmd.op = sou_pkg::OP_STEP;
        keep      = 1'b1;
      end
      sou_pkg::KIND_COEF: begin
        in_cmd.op = sou_pkg::OP_COEF;
        keep      = 32'(element_index) < 32'(COEF_DEPTH);
      end
      sou_pkg::KIND_EST: begin
        in_cmd.op = sou_pkg::OP_EST;
        keep      = 32'(element_index) < 32'(N_STATE);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (count == CNT_W'(sou_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign cmd_vld  = (count != '0);
  assign cmd      = queue[rd_ptr];
  assign pop      = cmd_vld && cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sou_back.sv
`default_nettype none

module sou_back #(
  parameter int N_STATE = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_vld,
  input  wire sou_pkg::cmd_t cmd,
  output logic             cmd_take,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       estimate_index,
  output logic [31:0]      estimate_value,
  output logic             saturated,
  output logic             last
);

  localparam int ROW_LEN    = N_STATE + sou_pkg::N_DRIVE + sou_pkg::N_MEASURE;
  localparam int COEF_DEPTH = N_STATE * ROW_LEN;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int ROW_W      = (N_STATE > 1) ? $clog2(N_STATE) : 1;
  localparam int TERM_W     = $clog2(ROW_LEN);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;

  logic [31:0] coef_mem [COEF_DEPTH];
  logic [31:0] mem_q;

  logic [31:0] est     [N_STATE];
  logic [31:0] new_vec [N_STATE];

  logic [31:0] drive;
  logic [31:0] rate;
  logic [31:0] angle;

  logic [CA_W-1:0]   coef_addr;
  logic [TERM_W-1:0] term;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  res_row;

  logic               s1_vld;
  logic               s1_first;
  logic               s1_last;
  logic [31:0]        s1_opnd;
  logic               s2_vld;
  logic               s2_first;
  logic               s2_last;
  logic signed [63:0] prod;
  logic [63:0]        acc;
  logic [63:0]        acc_sum;
  logic [63:0]        sum;
  logic               sum_vld;

  logic          en;
  logic          issuing;
  logic          out_free;
  logic          sum_mv;
  logic          start;
  logic          commit;
  logic          term_end;
  logic          row_end;
  logic [31:0]   opnd;
  sou_pkg::rs_t  rs;

  assign out_free = !out_valid || !out_stall;
  // freeze the whole datapath while a finished row cannot move on
  assign en       = !(sum_vld && !out_free);
  assign issuing  = (state == ST_ISSUE) && en;
  assign cmd_take = (state == ST_IDLE);
  assign start    = cmd_take && cmd_vld && (cmd.op == sou_pkg::OP_STEP);
  assign sum_mv   = sum_vld && out_free;
  assign commit   = sum_mv && (res_row == ROW_W'(N_STATE - 1));
  assign term_end = (term == TERM_W'(ROW_LEN - 1));
  assign row_end  = (row == ROW_W'(N_STATE - 1));
  assign rs       = sou_pkg::round_sat(sum);

  always_comb begin
    if (32'(term) < 32'(N_STATE)) begin
      opnd = est[term[ROW_W-1:0]];
    end else if (32'(term) == 32'(N_STATE)) begin
      opnd = drive;
    end else if (32'(term) == 32'(N_STATE + 1)) begin
      opnd = rate;
    end else begin
      opnd = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      coef_addr <= '0;
      term      <= '0;
      row       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state     <= ST_ISSUE;
            coef_addr <= '0;
            term      <= '0;
            row       <= '0;
          end
        end
        ST_ISSUE: begin
          if (en) begin
            coef_addr <= coef_addr + CA_W'(1);
            if (term_end) begin
              term <= '0;
              row  <= row + ROW_W'(1);
              if (row_end) begin
                state <= ST_DRAIN;
              end
            end else begin
              term <= term + TERM_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      drive <= cmd.drive;
      rate  <= cmd.rate;
      angle <= cmd.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd_vld && (cmd.op == sou_pkg::OP_COEF)) begin
      coef_mem[CA_W'(cmd.index)] <= cmd.value;
    end
    if (issuing) begin
      mem_q <= coef_mem[coef_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N_STATE; k++) begin
        est[k] <= '0;
      end
    end else if (cmd_take && cmd_vld && (cmd.op == sou_pkg::OP_EST)) begin
      est[cmd.index[ROW_W-1:0]] <= cmd.value;
    end else if (commit) begin
      for (int k = 0; k < N_STATE; k++) begin
        est[k] <= (k == N_STATE - 1) ? rs.value : new_vec[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_mv) begin
      new_vec[res_row] <= rs.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= (state == ST_ISSUE);
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_first <= (term == '0);
      s1_last  <= term_end;
      s1_opnd  <= opnd;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      prod     <= 64'($signed(mem_q) * $signed(s1_opnd));
    end
  end

  assign acc_sum = (s2_first ? 64'd0 : acc) + 64'(prod);

  always_ff @(posedge clk) begin
    if (en && s2_vld) begin
      if (s2_last) begin
        sum <= acc_sum;
      end else begin
        acc <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
      res_row <= '0;
    end else begin
      if (en && s2_vld && s2_last) begin
        sum_vld <= 1'b1;
      end else if (sum_mv) begin
        sum_vld <= 1'b0;
      end
      if (start) begin
        res_row <= '0;
      end else if (sum_mv) begin
        res_row <= res_row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_mv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_mv) begin
      estimate_index <= 4'(res_row);
      estimate_value <= rs.value;
      saturated      <= rs.clip;
      last           <= (res_row == ROW_W'(N_STATE - 1));
    end
  end

endmodule

`default_nettype wire
